>>> hw/rtl/lcdq_pkg.sv
`timescale 1ns / 1ps

package lcdq_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_BEGIN  = 2'd1,
      MODE_APPEND = 2'd2,
      MODE_FINISH = 2'd3
   } mode_type;

   // status codes on the response channel
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DROP  = 2'd2,
      STATUS_ORDER = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // top bit of the display address command
   localparam logic ADDR_CMD_BIT = 1'b1;

endpackage

>>> hw/rtl/lcd_nibble_transaction_queue.sv
`timescale 1ns / 1ps
// Transaction queue and 4-bit write sequencer for a character display.
// Request channel (req_*): one beat per item. mode selects tick, begin
// (column/row give the cursor address), append (character) or finish.
// Response channel (rsp_*): exactly one beat per request beat, in order,
// carrying status and, for a tick, the nibble, register select, enable
// strobe, end-of-transaction and idle flags.
// Begin, append, finish and an idle tick answer in the cycle after
// acceptance. A tick that drives a nibble answers after the registered
// read of the byte store and slot length memories, then the response
// register; the request side stalls during that read.
// Throughput: one item per cycle, but a nibble tick stalls the next one.
// A new request is taken while the last response is being taken; if the
// receiver stalls, the response holds and the request side stalls too.
// Reset empties the queue, drops any open transaction and clears the
// response valid flag; the memories are not cleared and need no sweep.
module lcd_nibble_transaction_queue import lcdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int SLOT_BYTES  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [5:0] req_column,
   input  logic       req_row,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_strobe_res,
   output logic [3:0] rsp_nibble,
   output logic       rsp_reg_select,
   output logic       rsp_done_res,
   output logic       rsp_idle
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int POS_W  = $clog2(SLOT_BYTES);
   localparam int ADDR_W = $clog2(QUEUE_DEPTH * SLOT_BYTES);

   logic              byte_wr_en;
   logic [ADDR_W-1:0] byte_wr_addr;
   logic [7:0]        byte_wr_data;
   logic [ADDR_W-1:0] byte_rd_addr;
   logic [7:0]        byte_rd_data;
   logic              len_wr_en;
   logic [SLOT_W-1:0] len_wr_addr;
   logic [POS_W-1:0]  len_wr_data;
   logic [SLOT_W-1:0] len_rd_addr;
   logic [POS_W-1:0]  len_rd_data;

   // queue control and sequencer
   lcdq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_character  (req_character),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_strobe_res (rsp_strobe_res),
      .rsp_nibble     (rsp_nibble),
      .rsp_reg_select (rsp_reg_select),
      .rsp_done_res   (rsp_done_res),
      .rsp_idle       (rsp_idle),
      .byte_wr_en     (byte_wr_en),
      .byte_wr_addr   (byte_wr_addr),
      .byte_wr_data   (byte_wr_data),
      .byte_rd_addr   (byte_rd_addr),
      .byte_rd_data   (byte_rd_data),
      .len_wr_en      (len_wr_en),
      .len_wr_addr    (len_wr_addr),
      .len_wr_data    (len_wr_data),
      .len_rd_addr    (len_rd_addr),
      .len_rd_data    (len_rd_data)
   );

   // text bytes, one slot of SLOT_BYTES per queue entry
   lcdq_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH * SLOT_BYTES)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (byte_wr_data),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   // byte count of each queued slot
   lcdq_ram #(
      .WIDTH (POS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_length (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

endmodule

>>> hw/rtl/lcdq_ram.sv
`timescale 1ns / 1ps

module lcdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hw/rtl/lcdq_ctrl.sv
`timescale 1ns / 1ps

module lcdq_ctrl import lcdq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int SLOT_BYTES  = 64
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [5:0] req_column,
   input  logic       req_row,
   input  logic [7:0] req_character,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_strobe_res,
   output logic [3:0] rsp_nibble,
   output logic       rsp_reg_select,
   output logic       rsp_done_res,
   output logic       rsp_idle,
   // byte store port
   output logic                                                       byte_wr_en,
   output logic [$clog2(QUEUE_DEPTH*SLOT_BYTES)-1:0]                  byte_wr_addr,
   output logic [7:0]                                                 byte_wr_data,
   output logic [$clog2(QUEUE_DEPTH*SLOT_BYTES)-1:0]                  byte_rd_addr,
   input  logic [7:0]                                                 byte_rd_data,
   // slot length port
   output logic                                                       len_wr_en,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0]   len_wr_addr,
   output logic [$clog2(SLOT_BYTES)-1:0]                              len_wr_data,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0]   len_rd_addr,
   input  logic [$clog2(SLOT_BYTES)-1:0]                              len_rd_data
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int POS_W  = $clog2(SLOT_BYTES);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int ADDR_W = $clog2(QUEUE_DEPTH * SLOT_BYTES);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              low_ff, low_in;
   logic              building_ff, building_in;
   logic [POS_W-1:0]  blen_ff, blen_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic [3:0] rsp_nibble_ff, rsp_nibble_in;
   logic       rsp_rs_ff, rsp_rs_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       rsp_idle_ff, rsp_idle_in;

   logic              accept;
   logic              tick_work;
   logic [SUM_W-1:0]  build_sum;
   logic [SLOT_W-1:0] build_slot;
   logic [SLOT_W-1:0] head_inc;
   logic [SLOT_W-1:0] act_slot;
   logic [SLOT_W-1:0] rd_slot;
   logic [POS_W-1:0]  rd_pos;
   logic [ADDR_W-1:0] build_base;
   logic [POS_W-1:0]  pos_next;
   logic              queue_full;

   assign accept    = req_valid && !req_stall;
   assign tick_work = active_ff || (count_ff != '0);

   // slot under construction sits behind the queued ones
   assign build_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign build_slot = (build_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       SLOT_W'(build_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(build_sum);
   assign build_base = ADDR_W'(build_slot) * ADDR_W'(SLOT_BYTES);

   // ring pointer arithmetic
   assign head_inc = (head_ff == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + SLOT_W'(1);
   assign act_slot = (head_ff == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : head_ff - SLOT_W'(1);

   // read address: the slot about to be activated is the current head
   assign rd_slot      = active_ff ? act_slot : head_ff;
   assign rd_pos       = active_ff ? pos_ff : '0;
   assign byte_rd_addr = ADDR_W'(rd_slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_pos);
   assign len_rd_addr  = rd_slot;

   // the transaction on the wire still holds its slot
   assign queue_full = (SUM_W'(count_ff) + SUM_W'(active_ff)) >= SUM_W'(QUEUE_DEPTH);

   assign pos_next = low_ff ? pos_ff + POS_W'(1) : pos_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_TICK) && tick_work) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: req_stall = rsp_valid_ff && rsp_stall;
         ST_READ: req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // queue state, memory writes and response register
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      building_in  = building_ff;
      blen_in      = blen_ff;

      byte_wr_en   = 1'b0;
      byte_wr_addr = build_base + ADDR_W'(blen_ff);
      byte_wr_data = req_character;
      len_wr_en    = 1'b0;
      len_wr_addr  = build_slot;
      len_wr_data  = blen_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_strobe_in = rsp_strobe_ff;
      rsp_nibble_in = rsp_nibble_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_idle_in   = rsp_idle_ff;

      if (state_ff == ST_READ) begin
         // drive one nibble of the fetched byte and advance
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_strobe_in = 1'b1;
         rsp_nibble_in = low_ff ? byte_rd_data[3:0] : byte_rd_data[7:4];
         rsp_rs_in     = pos_ff != '0;
         rsp_idle_in   = 1'b0;
         rsp_done_in   = 1'b0;
         low_in        = !low_ff;
         pos_in        = pos_next;
         if (pos_next >= len_rd_data) begin
            rsp_done_in = 1'b1;
            active_in   = 1'b0;
         end
      end else if (accept) begin
         rsp_status_in = STATUS_OK;
         rsp_strobe_in = 1'b0;
         rsp_nibble_in = '0;
         rsp_rs_in     = 1'b0;
         rsp_done_in   = 1'b0;
         rsp_idle_in   = 1'b0;
         unique case (req_mode)
            MODE_TICK: begin
               // pull the oldest queued slot when nothing is on the wire
               if (!active_ff && (count_ff != '0)) begin
                  head_in   = head_inc;
                  count_in  = count_ff - CNT_W'(1);
                  active_in = 1'b1;
                  pos_in    = '0;
                  low_in    = 1'b0;
               end
               if (!tick_work) begin
                  rsp_valid_in = 1'b1;
                  rsp_idle_in  = 1'b1;
               end
            end
            MODE_BEGIN: begin
               rsp_valid_in = 1'b1;
               if (!building_ff && queue_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  byte_wr_en   = 1'b1;
                  byte_wr_addr = build_base;
                  byte_wr_data = {ADDR_CMD_BIT, req_row, req_column};
                  blen_in      = POS_W'(1);
                  building_in  = 1'b1;
               end
            end
            MODE_APPEND: begin
               rsp_valid_in = 1'b1;
               if (!building_ff) begin
                  rsp_status_in = STATUS_ORDER;
               end else if (blen_ff >= POS_W'(SLOT_BYTES - 1)) begin
                  rsp_status_in = STATUS_DROP;
               end else begin
                  byte_wr_en = 1'b1;
                  blen_in    = blen_ff + POS_W'(1);
               end
            end
            MODE_FINISH: begin
               rsp_valid_in = 1'b1;
               if (!building_ff) begin
                  rsp_status_in = STATUS_ORDER;
               end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
                  building_in   = 1'b0;
                  blen_in       = '0;
               end else begin
                  len_wr_en   = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  building_in = 1'b0;
                  blen_in     = '0;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         low_ff       <= 1'b0;
         building_ff  <= 1'b0;
         blen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         building_ff  <= building_in;
         blen_ff      <= blen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_strobe_ff <= rsp_strobe_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_idle_ff   <= rsp_idle_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_strobe_res = rsp_strobe_ff;
   assign rsp_nibble     = rsp_nibble_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_idle       = rsp_idle_ff;

endmodule

>>> hw/rtl/lcdq_checker.sv
`timescale 1ns / 1ps

module lcdq_checker import lcdq_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_strobe_res,
   input logic [3:0] rsp_nibble,
   input logic       rsp_reg_select,
   input logic       rsp_done_res,
   input logic       rsp_idle
);

   // hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_nibble)
         && $stable(rsp_strobe_res) && $stable(rsp_done_res) && $stable(rsp_idle))
      else $error("stalled response beat changed");

   // no response beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a beat without strobe carries no nibble, select or end flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_strobe_res |-> rsp_nibble == 4'd0 && !rsp_reg_select && !rsp_done_res)
      else $error("quiet beat drives display lines");

   // a driven nibble is a tick beat: status ok and not idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strobe_res |-> rsp_status == STATUS_OK && !rsp_idle)
      else $error("strobed beat with error status or idle");

   // an idle tick reports ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> rsp_status == STATUS_OK)
      else $error("idle beat with error status");

endmodule

bind lcd_nibble_transaction_queue lcdq_checker u_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import lcdq_pkg::*;

   localparam int QD    = 8;
   localparam int SLOT  = 64;
   localparam int ITEMS = 850;
   localparam int LIMIT = 200000;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] column;
      logic       row;
      logic [7:0] character;
   } cmd_beat_t;

   typedef struct packed {
      status_type status;
      logic       strobe;
      logic [3:0] nibble;
      logic       reg_select;
      logic       done;
      logic       idle;
   } bus_beat_t;

   typedef struct packed {
      cmd_beat_t cmd;
      logic      typed;
      bus_beat_t want;
   } plan_row_t;

   // directed opening: reset, ordering errors, extremes, restart, empty text
   localparam plan_row_t DIRECTED [26] = '{
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b1}},
      '{'{MODE_APPEND, 6'd63, 1'b1, 8'hFF}, 1'b1, '{STATUS_ORDER, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_FINISH, 6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_ORDER, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_BEGIN,  6'd63, 1'b1, 8'h00}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_APPEND, 6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_APPEND, 6'd63, 1'b1, 8'hFF}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_FINISH, 6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd63, 1'b1, 8'hFF}, 1'b1, '{STATUS_OK,    1'b1, 4'hF, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b1, 4'hF, 1'b0, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b1, 4'h0, 1'b1, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b1, 4'h0, 1'b1, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b1, 4'hF, 1'b1, 1'b0, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b1, 4'hF, 1'b1, 1'b1, 1'b0}},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b1, '{STATUS_OK,    1'b0, 4'h0, 1'b0, 1'b0, 1'b1}},
      '{'{MODE_BEGIN,  6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_BEGIN,  6'd5,  1'b1, 8'h3C}, 1'b0, '0},
      '{'{MODE_FINISH, 6'd17, 1'b1, 8'hC3}, 1'b0, '0},
      '{'{MODE_BEGIN,  6'd42, 1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_APPEND, 6'd0,  1'b0, 8'hA5}, 1'b0, '0},
      '{'{MODE_FINISH, 6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0},
      '{'{MODE_TICK,   6'd0,  1'b0, 8'h00}, 1'b0, '0}
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode      = MODE_TICK;
   logic [5:0] req_column    = '0;
   logic       req_row       = 1'b0;
   logic [7:0] req_character = '0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_strobe_res;
   logic [3:0] rsp_nibble;
   logic       rsp_reg_select;
   logic       rsp_done_res;
   logic       rsp_idle;

   // shadow of the queue and sequencer
   logic [7:0] text_mem [0:QD*SLOT-1];
   logic [5:0] slot_len [0:QD-1];
   logic [2:0] q_head    = '0;
   logic [3:0] q_pending = '0;
   logic       sending   = 1'b0;
   logic [5:0] byte_pos  = '0;
   logic       low_nib   = 1'b0;
   logic       open_txn  = 1'b0;
   logic [5:0] open_len  = '0;

   bus_beat_t pending_bus_beats [$];

   int  errors       = 0;
   int  cycles       = 0;
   int  beats_sent   = 0;
   int  rsp_count    = 0;
   int  n_strobes    = 0;
   int  n_ended      = 0;
   int  n_full       = 0;
   int  n_drop       = 0;
   int  n_order      = 0;
   bit  steady       = 1'b0;

   lcd_nibble_transaction_queue #(
      .QUEUE_DEPTH(QD),
      .SLOT_BYTES (SLOT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_character (req_character),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_strobe_res(rsp_strobe_res),
      .rsp_nibble    (rsp_nibble),
      .rsp_reg_select(rsp_reg_select),
      .rsp_done_res  (rsp_done_res),
      .rsp_idle      (rsp_idle)
   );

   always #1 clock = ~clock;

   function automatic void flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   // advance the shadow by one command and return the bus beat it produces
   function automatic bus_beat_t next_bus_beat(input cmd_beat_t c);
      bus_beat_t  r;
      logic [2:0] slot;
      logic [7:0] b;
      r = '0;
      slot = q_head + q_pending[2:0];
      case (c.mode)
         MODE_TICK: begin
            // pull the oldest queued transaction when the bus is free
            if (!sending && q_pending != 0) begin
               q_head    = q_head + 3'd1;
               q_pending = q_pending - 4'd1;
               sending   = 1'b1;
               byte_pos  = '0;
               low_nib   = 1'b0;
            end
            if (sending) begin
               slot         = q_head - 3'd1;
               b            = text_mem[{slot, byte_pos}];
               r.strobe     = 1'b1;
               r.nibble     = low_nib ? b[3:0] : b[7:4];
               r.reg_select = (byte_pos != 0);
               low_nib      = ~low_nib;
               if (!low_nib) byte_pos = byte_pos + 6'd1;
               if (byte_pos >= slot_len[slot]) begin
                  r.done  = 1'b1;
                  sending = 1'b0;
               end
            end else begin
               r.idle = 1'b1;
            end
         end
         MODE_BEGIN: begin
            // the slot on the bus still counts against the ring
            if (!open_txn && q_pending + sending >= QD) begin
               r.status = STATUS_FULL;
            end else begin
               text_mem[{slot, 6'd0}] = {ADDR_CMD_BIT, {1'b0, c.column} + {c.row, 6'd0}};
               open_len = 6'd1;
               open_txn = 1'b1;
            end
         end
         MODE_APPEND: begin
            if (!open_txn) begin
               r.status = STATUS_ORDER;
            end else if (open_len >= 6'(SLOT - 1)) begin
               r.status = STATUS_DROP;
            end else begin
               text_mem[{slot, open_len}] = c.character;
               open_len = open_len + 6'd1;
            end
         end
         MODE_FINISH: begin
            if (!open_txn) begin
               r.status = STATUS_ORDER;
            end else begin
               if (q_pending >= QD) begin
                  r.status = STATUS_FULL;
               end else begin
                  slot_len[slot] = open_len;
                  q_pending = q_pending + 4'd1;
               end
               open_txn = 1'b0;
               open_len = '0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic cmd_beat_t random_cmd(input mode_type m);
      cmd_beat_t c;
      c.mode      = m;
      c.column    = 6'($urandom_range(63));
      c.row       = 1'($urandom_range(1));
      c.character = 8'($urandom_range(255));
      return c;
   endfunction

   // present one command, hold it until taken, then record what it should produce
   task automatic issue_cmd(input cmd_beat_t c, input logic typed, input bus_beat_t want);
      bus_beat_t pred;
      if (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= c.mode;
      req_column    <= c.column;
      req_row       <= c.row;
      req_character <= c.character;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = next_bus_beat(c);
      pending_bus_beats.push_back(typed ? want : pred);
      n_strobes += pred.strobe;
      n_ended   += pred.done;
      n_full    += (pred.status == STATUS_FULL);
      n_drop    += (pred.status == STATUS_DROP);
      n_order   += (pred.status == STATUS_ORDER);
      beats_sent++;
      steady = (beats_sent >= 300 && beats_sent < 420);
   endtask

   task automatic send_ticks(input int pct);
      while ($urandom_range(99) < pct) issue_cmd(random_cmd(MODE_TICK), 1'b0, '0);
   endtask

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // take response beats, compare against the oldest expectation, stall at random
   always @(posedge clock) begin
      bus_beat_t got;
      bus_beat_t want;
      got = '{status_type'(rsp_status), rsp_strobe_res, rsp_nibble, rsp_reg_select,
              rsp_done_res, rsp_idle};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bus_beats.size() == 0) begin
            flag_error($sformatf("response %0d arrived with nothing expected", rsp_count));
         end else begin
            want = pending_bus_beats.pop_front();
            if (got.status !== want.status || got.strobe !== want.strobe ||
                got.nibble !== want.nibble || got.reg_select !== want.reg_select ||
                got.done !== want.done || got.idle !== want.idle)
               flag_error($sformatf({"response %0d: expected status=%0d strobe=%b nibble=%h ",
                  "rs=%b done=%b idle=%b, got status=%0d strobe=%b nibble=%h rs=%b done=%b ",
                  "idle=%b"}, rsp_count, want.status, want.strobe, want.nibble,
                  want.reg_select, want.done, want.idle, got.status, got.strobe,
                  got.nibble, got.reg_select, got.done, got.idle));
         end
         rsp_count++;
      end
      rsp_stall <= !steady && ($urandom_range(99) < 33);
   end

   initial begin
      int tick_pct;
      int text_len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) issue_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);

      // bursts of well-formed transactions at varying tick rates, some noise
      while (beats_sent < ITEMS) begin
         case ($urandom_range(3))
            0: tick_pct = 0;
            1: tick_pct = 15;
            2: tick_pct = 50;
            default: tick_pct = 80;
         endcase
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(99) < 8) begin
               repeat ($urandom_range(1, 3))
                  issue_cmd(random_cmd(mode_type'($urandom_range(3))), 1'b0, '0);
            end else begin
               send_ticks(tick_pct);
               issue_cmd(random_cmd(MODE_BEGIN), 1'b0, '0);
               if ($urandom_range(99) < 8) issue_cmd(random_cmd(MODE_BEGIN), 1'b0, '0);
               text_len = ($urandom_range(99) < 2) ? $urandom_range(60, 66)
                                                    : $urandom_range(0, 6);
               repeat (text_len) begin
                  send_ticks(tick_pct);
                  issue_cmd(random_cmd(MODE_APPEND), 1'b0, '0);
               end
               // leave some transactions unfinished
               if ($urandom_range(99) >= 5) begin
                  send_ticks(tick_pct);
                  issue_cmd(random_cmd(MODE_FINISH), 1'b0, '0);
               end
            end
         end
      end

      // drain the ring, then one tick that must find the bus idle
      while (sending || q_pending != 0) issue_cmd(random_cmd(MODE_TICK), 1'b0, '0);
      issue_cmd(random_cmd(MODE_TICK), 1'b0, '0);
      req_valid <= 1'b0;

      while (pending_bus_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request beats: %0d nibbles, %0d transactions sent out,",
               beats_sent, n_strobes, n_ended);
      $display("%0d full rejects, %0d dropped characters, %0d out-of-order items, %0d errors",
               n_full, n_drop, n_order, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
